### rtl/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared types, constants and helpers for the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnd_pkg;

   // Largest image side the block handles.
   localparam int unsigned MAX_DIM     = 4096;

   // Field widths.
   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned COORD_W     = 12;
   localparam int unsigned PIXEL_W     = 24;
   localparam int unsigned PROD_W      = COORD_W + SIZE_W;

   // Depth of the queue between front and back (a power of two).
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W    = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_WIDTH   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_HEIGHT  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_WIDTH  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_HEIGHT = 8'd3;

   // Effective image sizes, already clamped to 1..MAX_DIM.
   typedef struct packed {
      logic [SIZE_W-1:0] in_width;
      logic [SIZE_W-1:0] in_height;
      logic [SIZE_W-1:0] out_width;
      logic [SIZE_W-1:0] out_height;
   } size_type;

   // One classified pixel, handed from front to back.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } entry_type;

   // A size of zero counts as one, and anything above MAX_DIM as MAX_DIM.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = SIZE_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/nnd_front.sv
// ----------------------------------------------------------------------------
// nnd_front
// Accepts source pixels, tracks the source row and column in raster order,
// flags the last pixel of a frame and pushes each item into the queue.
// ----------------------------------------------------------------------------
module nnd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  nnd_pkg::size_type                sizes,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nnd_pkg::PIXEL_W-1:0]      req_tdata,   // [23:0] pixel_in
   output logic                             push,
   output nnd_pkg::entry_type               push_entry,
   input  logic                             queue_full
);

   logic [nnd_pkg::COORD_W-1:0] row_ff, row_in;
   logic [nnd_pkg::COORD_W-1:0] col_ff, col_in;
   logic [nnd_pkg::COORD_W-1:0] row_eff, col_eff;
   logic                        row_end, frame_end;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // A counter that is out of range after a size change restarts at zero.
   always_comb begin
      row_eff = ({1'b0, row_ff} >= sizes.in_height) ? '0 : row_ff;
      col_eff = ({1'b0, col_ff} >= sizes.in_width)  ? '0 : col_ff;
      row_end   = ({1'b0, col_eff} == sizes.in_width - nnd_pkg::SIZE_W'(1));
      frame_end = ({1'b0, row_eff} == sizes.in_height - nnd_pkg::SIZE_W'(1));
   end

   // Item handed to the back.
   always_comb begin
      push_entry.row   = row_eff;
      push_entry.col   = col_eff;
      push_entry.pixel = req_tdata;
      push_entry.last  = row_end && frame_end;
   end

   // Raster counters advance once per accepted item.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_eff + nnd_pkg::COORD_W'(1);
         end else begin
            col_in = col_eff + nnd_pkg::COORD_W'(1);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

### rtl/nnd_queue.sv
// ----------------------------------------------------------------------------
// nnd_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module nnd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nnd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output nnd_pkg::entry_type  pop_entry
);

   localparam int unsigned PTR_W = (nnd_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(nnd_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(nnd_pkg::QUEUE_DEPTH + 1);

   nnd_pkg::entry_type   slot_ff [nnd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(nnd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/nnd_back.sv
// ----------------------------------------------------------------------------
// nnd_back
// Scales the source coordinates of one item at a time: a multiply, then a
// restoring division one quotient bit per cycle for row and column in
// parallel, then a registered result on the output channel.
// ----------------------------------------------------------------------------
module nnd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  nnd_pkg::size_type                sizes,
   input  logic                             not_empty,
   input  nnd_pkg::entry_type               pop_entry,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [47:0]                      rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int unsigned CW     = nnd_pkg::COORD_W;
   localparam int unsigned SW     = nnd_pkg::SIZE_W;
   localparam int unsigned PW     = nnd_pkg::PROD_W;
   localparam int unsigned STEP_W = $clog2(CW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   nnd_pkg::entry_type          item_ff, item_in;
   logic [SW-1:0]               rem_row_ff, rem_row_in, rem_col_ff, rem_col_in;
   logic [CW-1:0]               num_row_ff, num_row_in, num_col_ff, num_col_in;
   logic                        out_valid_ff, out_valid_in;
   logic [CW-1:0]               out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [nnd_pkg::PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic                        out_last_ff, out_last_in;

   logic [PW-1:0]               prod_row, prod_col;
   logic [SW:0]                 trial_row, trial_col;
   logic                        fit_row, fit_col;
   logic                        out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pixel_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && not_empty;

   // Products of source position and destination size.
   assign prod_row = PW'(item_ff.row) * PW'(sizes.out_height);
   assign prod_col = PW'(item_ff.col) * PW'(sizes.out_width);

   // One restoring division step on each coordinate.
   always_comb begin
      trial_row = {rem_row_ff, num_row_ff[CW-1]};
      trial_col = {rem_col_ff, num_col_ff[CW-1]};
      fit_row   = (trial_row >= {1'b0, sizes.in_height});
      fit_col   = (trial_col >= {1'b0, sizes.in_width});
   end

   // Sequencer and datapath.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      item_in      = item_ff;
      rem_row_in   = rem_row_ff;
      rem_col_in   = rem_col_ff;
      num_row_in   = num_row_ff;
      num_col_in   = num_col_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               item_in  = pop_entry;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The product is below size times 4096, so its top bits
            // already sit below the divisor.
            rem_row_in = prod_row[PW-1:CW];
            num_row_in = prod_row[CW-1:0];
            rem_col_in = prod_col[PW-1:CW];
            num_col_in = prod_col[CW-1:0];
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_row_in = fit_row ? SW'(trial_row - {1'b0, sizes.in_height})
                                 : trial_row[SW-1:0];
            rem_col_in = fit_col ? SW'(trial_col - {1'b0, sizes.in_width})
                                 : trial_col[SW-1:0];
            num_row_in = {num_row_ff[CW-2:0], fit_row};
            num_col_in = {num_col_ff[CW-2:0], fit_col};
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The quotients now sit in the numerator shift registers.
            if (out_free) begin
               out_valid_in = 1'b1;
               out_row_in   = num_row_ff;
               out_col_in   = num_col_ff;
               out_pixel_in = item_ff.pixel;
               out_last_in  = item_ff.last;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      item_ff      <= item_in;
      rem_row_ff   <= rem_row_in;
      rem_col_ff   <= rem_col_in;
      num_row_ff   <= num_row_in;
      num_col_ff   <= num_col_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

endmodule

### rtl/nearest_neighbor_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Streams source pixels in raster order and emits one destination write per
// pixel at the nearest-neighbor scaled row and column.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: pixel_in
//   rsp      out        rsp_tvalid/rsp_tready  tdata: dest_row, dest_col,
//                                              pixel_out; tlast: last_of_frame
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Each item passes through the back in order: it is taken from the
// queue, multiplied, put through 12 divider steps (one quotient bit per
// cycle) and loaded into the output register. The divider sets the rate.
// The front and a two-item queue keep accepting while the back works.
// Reset clears the raster counters, the queue and the output valid, and
// sets all size registers to 1. A stalled output holds its item and the
// back waits before loading the next.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input pixels.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // [23:0] pixel_in
   // Destination writes.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [47:0]                          rsp_tdata,  // [11:0] dest_row,
                                                            // [23:12] dest_col,
                                                            // [47:24] pixel_out
   output logic                                 rsp_tlast,  // last_of_frame
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nnd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nnd_pkg::SIZE_W-1:0]           csr_data
);

   logic [nnd_pkg::SIZE_W-1:0] in_width_ff,   in_width_in;
   logic [nnd_pkg::SIZE_W-1:0] in_height_ff,  in_height_in;
   logic [nnd_pkg::SIZE_W-1:0] out_width_ff,  out_width_in;
   logic [nnd_pkg::SIZE_W-1:0] out_height_ff, out_height_in;
   nnd_pkg::size_type          sizes;
   logic                       csr_write;

   logic                       push, queue_full, pop, not_empty;
   nnd_pkg::entry_type         push_entry, pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Size registers; unknown indexes are ignored.
   always_comb begin
      in_width_in   = in_width_ff;
      in_height_in  = in_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            nnd_pkg::REG_IN_WIDTH:   in_width_in   = csr_data;
            nnd_pkg::REG_IN_HEIGHT:  in_height_in  = csr_data;
            nnd_pkg::REG_OUT_WIDTH:  out_width_in  = csr_data;
            nnd_pkg::REG_OUT_HEIGHT: out_height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= nnd_pkg::SIZE_W'(1);
         in_height_ff  <= nnd_pkg::SIZE_W'(1);
         out_width_ff  <= nnd_pkg::SIZE_W'(1);
         out_height_ff <= nnd_pkg::SIZE_W'(1);
      end else begin
         in_width_ff   <= in_width_in;
         in_height_ff  <= in_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
      end
   end

   // Clamped sizes seen by both halves.
   always_comb begin
      sizes.in_width   = nnd_pkg::eff_size(in_width_ff);
      sizes.in_height  = nnd_pkg::eff_size(in_height_ff);
      sizes.out_width  = nnd_pkg::eff_size(out_width_ff);
      sizes.out_height = nnd_pkg::eff_size(out_height_ff);
   end

   nnd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sizes      (sizes),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   nnd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   nnd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .sizes      (sizes),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/nnd_checker.sv
// ----------------------------------------------------------------------------
// nnd_checker
// Port-level checks for the downscaler: output stall behavior and the count
// of items between the input and the output channel.
// ----------------------------------------------------------------------------
module nnd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast
);

   // Queue plus one item in the back plus the output register.
   localparam int unsigned MAX_INFLIGHT = nnd_pkg::QUEUE_DEPTH + 2;
   localparam int unsigned FLIGHT_W     = $clog2(MAX_INFLIGHT + 2);

   logic                req_take, rsp_take;
   logic [FLIGHT_W-1:0] inflight_ff, inflight_in;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // Items accepted but not yet delivered.
   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + FLIGHT_W'(1);
      end else if (rsp_take && !req_take) begin
         inflight_in = inflight_ff - FLIGHT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   a_no_invented_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("result shown with no item in flight");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= FLIGHT_W'(MAX_INFLIGHT))
      else $error("more items in flight than the design can hold");

endmodule

bind nearest_neighbor_downscaler nnd_checker u_nnd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
